// File: design/sensor_line_frame_parser_defines.svh
// Assertion macros shared by the parser modules.
`ifndef SENSOR_LINE_FRAME_PARSER_DEFINES_SVH
`define SENSOR_LINE_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SLFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define SLFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SLFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: design/slfp_pkg.sv
package slfp_pkg;

    localparam logic [2:0] ST_STORED = 3'd0;
    localparam logic [2:0] ST_RANGE  = 3'd1;
    localparam logic [2:0] ST_LENGTH = 3'd2;
    localparam logic [2:0] ST_FORMAT = 3'd3;
    localparam logic [2:0] ST_CHAN   = 3'd4;
    localparam logic [2:0] ST_ID     = 3'd5;

    localparam logic [2:0] CFG_ID0   = 3'd0;
    localparam logic [2:0] CFG_ID1   = 3'd1;
    localparam logic [2:0] CFG_ID2   = 3'd2;
    localparam logic [2:0] CFG_ID3   = 3'd3;
    localparam logic [2:0] CFG_LOW   = 3'd4;
    localparam logic [2:0] CFG_HIGH  = 3'd5;
    localparam logic [2:0] CFG_FAULT = 3'd6;

    localparam int ID_SLOTS    = 4;
    localparam int MAG_MAX     = 999999;
    localparam int ERR_WRAP    = 100000;
    localparam int QUEUE_DEPTH = 2;

    // One finished line, handed from the parser to the checker.
    typedef struct packed {
        logic [2:0]         status;    // early verdict when lookup is clear
        logic               lookup;    // id match and range check still pending
        logic               temp_bad;  // temperature text unusable
        logic [63:0]        id;
        logic signed [20:0] value;     // signed millidegrees, saturated
    } t_line_rec;

    function automatic logic [9:0] pow10(input logic [1:0] k);
        logic [9:0] r;
        unique case (k)
            2'd0: r = 10'd1;
            2'd1: r = 10'd10;
            2'd2: r = 10'd100;
            2'd3: r = 10'd1000;
        endcase
        return r;
    endfunction

endpackage

// File: design/slfp_front.sv
module slfp_front import slfp_pkg::*; #(
    parameter int MIN_LINE_BYTES  = 30,
    parameter int MAX_LINE_BYTES  = 32,
    parameter int FRACTION_PLACES = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic      i_space,
    output logic      o_push,
    output t_line_rec o_rec
);

    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_CM = 8'h2C;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_DT = 8'h2E;

    function automatic logic [7:0] hdr_char(input logic [2:0] p);
        logic [7:0] r;
        unique case (p)
            3'd0:    r = CH_S;
            3'd2:    r = CH_CM;
            default: r = CH_0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b0, 4'(c[3:0] + 4'd9)};
        else r = 5'h10;
        return r;
    endfunction

    logic        r_synced, n_synced;
    logic [2:0]  r_hdr, n_hdr;
    logic [5:0]  r_len, n_len;
    logic [2:0]  r_field, n_field;
    logic [7:0]  r_chan, n_chan;
    logic [7:0]  r_idx, n_idx;
    logic [63:0] r_id, n_id;
    logic [4:0]  r_idcnt, n_idcnt;
    logic [3:0]  r_sign, n_sign;
    logic [19:0] r_mag, n_mag;
    logic [1:0]  r_frac, n_frac;
    logic        r_badstart, n_badstart, r_nonnum, n_nonnum, r_tempbad, n_tempbad;
    logic        r_dot, n_dot, r_digit, n_digit;
    logic [7:0]  r_prev, n_prev;

    logic        accept, is_digit;
    logic [3:0]  dval;
    logic [2:0]  hdr_next;
    logic [4:0]  hv;
    logic [11:0] chan_acc, idx_acc;
    logic [7:0]  sign_acc;
    logic [23:0] mag_acc;
    logic [29:0] scaled;
    logic [19:0] mag_sat;
    logic [2:0]  pre_status;
    logic        pre_lookup;

    assign o_ready  = i_space;
    assign accept   = i_valid && i_space;
    assign is_digit = (i_rx_byte >= 8'h30) && (i_rx_byte <= 8'h39);
    assign dval     = i_rx_byte[3:0];
    assign hv       = hex_val(i_rx_byte);
    assign chan_acc = 12'(r_chan) * 12'd10 + 12'(dval);
    assign idx_acc  = 12'(r_idx) * 12'd10 + 12'(dval);
    assign sign_acc = 8'(r_sign) * 8'd10 + 8'(dval);
    assign mag_acc  = 24'(r_mag) * 24'd10 + 24'(dval);
    assign hdr_next = (i_rx_byte == hdr_char(r_hdr)) ? 3'(r_hdr + 3'd1)
                    : ((i_rx_byte == CH_S) ? 3'd1 : 3'd0);

    // Pad missing fraction digits, then saturate.
    assign scaled  = 30'(r_mag) * 30'(pow10(2'(3'(FRACTION_PLACES) - {1'b0, r_frac})));
    assign mag_sat = (scaled > 30'(MAG_MAX)) ? 20'(MAG_MAX) : scaled[19:0];

    always_comb begin
        pre_lookup = 1'b0;
        pre_status = ST_STORED;
        if (r_len < 6'(MIN_LINE_BYTES) || r_len > 6'(MAX_LINE_BYTES)) begin
            pre_status = ST_LENGTH;
        end else if (r_badstart || r_prev != CH_CR || r_field < 3'd4) begin
            pre_status = ST_FORMAT;
        end else if (r_chan > 8'd1 || r_idx > 8'd1) begin
            pre_status = ST_CHAN;
        end else if (r_idcnt != 5'd16) begin
            pre_status = ST_ID;
        end else begin
            pre_lookup = 1'b1;
        end
    end

    always_comb begin
        o_rec.status   = pre_status;
        o_rec.lookup   = pre_lookup;
        o_rec.temp_bad = r_tempbad || !r_digit;
        o_rec.id       = r_id;
        o_rec.value    = (r_sign == 4'd0) ? -$signed({1'b0, mag_sat})
                                          : $signed({1'b0, mag_sat});
    end

    always_comb begin
        n_synced = r_synced;  n_hdr = r_hdr;     n_len = r_len;
        n_field = r_field;    n_chan = r_chan;   n_idx = r_idx;
        n_id = r_id;          n_idcnt = r_idcnt; n_sign = r_sign;
        n_mag = r_mag;        n_frac = r_frac;   n_prev = r_prev;
        n_badstart = r_badstart; n_nonnum = r_nonnum; n_tempbad = r_tempbad;
        n_dot = r_dot;        n_digit = r_digit;
        o_push = 1'b0;
        if (accept) begin
            if (!r_synced) begin
                if (hdr_next == 3'd5) begin
                    // header becomes the first line: length five, in the index field
                    n_synced = 1'b1; n_hdr = 3'd0;
                    n_len = 6'd5; n_field = 3'd1; n_chan = 8'd0; n_idx = 8'd0;
                    n_id = '0; n_idcnt = '0; n_sign = '0; n_mag = '0; n_frac = '0;
                    n_badstart = 1'b0; n_nonnum = 1'b0; n_tempbad = 1'b0;
                    n_dot = 1'b0; n_digit = 1'b0; n_prev = CH_0;
                end else begin
                    n_hdr = hdr_next;
                end
            end else if (i_rx_byte == CH_LF) begin
                o_push = 1'b1;
                n_len = '0; n_field = '0; n_chan = '0; n_idx = '0;
                n_id = '0; n_idcnt = '0; n_sign = '0; n_mag = '0; n_frac = '0;
                n_badstart = 1'b0; n_nonnum = 1'b0; n_tempbad = 1'b0;
                n_dot = 1'b0; n_digit = 1'b0; n_prev = i_rx_byte;
            end else begin
                n_prev = i_rx_byte;
                if (r_len != 6'd63) n_len = 6'(r_len + 6'd1);
                if (r_len == 6'd0) begin
                    if (i_rx_byte != CH_S) n_badstart = 1'b1;
                end else if (r_field <= 3'd4) begin
                    if (i_rx_byte == CH_CM || (r_field == 3'd4 && i_rx_byte == CH_CR)) begin
                        if (r_nonnum) begin
                            if (r_field == 3'd0) n_chan = '0;
                            else if (r_field == 3'd1) n_idx = '0;
                            else if (r_field == 3'd3) n_sign = '0;
                        end
                        n_nonnum = 1'b0;
                        n_field = 3'(r_field + 3'd1);
                    end else begin
                        unique case (r_field)
                            3'd0: begin
                                if (is_digit)
                                    n_chan = (chan_acc > 12'd255) ? 8'd255 : chan_acc[7:0];
                                else n_nonnum = 1'b1;
                            end
                            3'd1: begin
                                if (is_digit)
                                    n_idx = (idx_acc > 12'd255) ? 8'd255 : idx_acc[7:0];
                                else n_nonnum = 1'b1;
                            end
                            3'd2: begin
                                if (hv[4]) n_idcnt = 5'd31;
                                else begin
                                    n_id = {r_id[59:0], hv[3:0]};
                                    if (r_idcnt != 5'd31) n_idcnt = 5'(r_idcnt + 5'd1);
                                end
                            end
                            3'd3: begin
                                if (is_digit)
                                    n_sign = (sign_acc > 8'd15) ? 4'd15 : sign_acc[3:0];
                                else n_nonnum = 1'b1;
                            end
                            default: begin
                                if (is_digit) begin
                                    n_digit = 1'b1;
                                    if (!r_dot || ({1'b0, r_frac} < 3'(FRACTION_PLACES))) begin
                                        n_mag = (mag_acc > 24'(MAG_MAX)) ? 20'(MAG_MAX)
                                                                         : mag_acc[19:0];
                                        if (r_dot) n_frac = 2'(r_frac + 2'd1);
                                    end
                                end else if (i_rx_byte == CH_DT && !r_dot) begin
                                    n_dot = 1'b1;
                                end else begin
                                    n_tempbad = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synced <= 1'b0; r_hdr <= '0; r_len <= '0; r_field <= '0;
            r_chan <= '0; r_idx <= '0; r_id <= '0; r_idcnt <= '0; r_sign <= '0;
            r_mag <= '0; r_frac <= '0; r_prev <= '0;
            r_badstart <= 1'b0; r_nonnum <= 1'b0; r_tempbad <= 1'b0;
            r_dot <= 1'b0; r_digit <= 1'b0;
        end else begin
            r_synced <= n_synced; r_hdr <= n_hdr; r_len <= n_len; r_field <= n_field;
            r_chan <= n_chan; r_idx <= n_idx; r_id <= n_id; r_idcnt <= n_idcnt;
            r_sign <= n_sign; r_mag <= n_mag; r_frac <= n_frac; r_prev <= n_prev;
            r_badstart <= n_badstart; r_nonnum <= n_nonnum; r_tempbad <= n_tempbad;
            r_dot <= n_dot; r_digit <= n_digit;
        end
    end

`include "sensor_line_frame_parser_defines.svh"
    `SLFP_ASSERT_NEXT(a_sync_sticky, i_clk, i_rst_n, r_synced, r_synced, "sync lost")
    `SLFP_ASSERT_NOW(a_push_synced, i_clk, i_rst_n, o_push, r_synced && i_space,
                     "request pushed before sync or into a full queue")

endmodule

// File: design/slfp_queue.sv
module slfp_queue import slfp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_line_rec i_rec,
    output logic      o_space,
    output logic      o_valid,
    input  logic      i_pop,
    output t_line_rec o_rec
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_line_rec r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    assign o_space = (r_count != CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_count <= '0;
        end else begin
            if (i_push) r_wr <= bump(r_wr);
            if (i_pop) r_rd <= bump(r_rd);
            if (i_push && !i_pop) r_count <= CW'(r_count + 1'b1);
            else if (i_pop && !i_push) r_count <= CW'(r_count - 1'b1);
        end
    end

`include "sensor_line_frame_parser_defines.svh"
    `SLFP_ASSERT_NOW(a_q_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(QUEUE_DEPTH),
                     "queue count overflow")
    `SLFP_ASSERT_NOW(a_q_pop, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")

endmodule

// File: design/slfp_back.sv
module slfp_back import slfp_pkg::*; #(
    parameter int SLOT_COUNT = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_pop,
    input  t_line_rec           i_rec,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_status,
    output logic [1:0]          o_slot,
    output logic signed [20:0]  o_temperature,
    output logic [16:0]         o_error_total
);

    logic [63:0] r_sid [ID_SLOTS];
    logic [18:0] r_low, r_high, r_fault;

    logic               r_valid;
    logic [2:0]         r_status;
    logic [1:0]         r_slot;
    logic signed [20:0] r_temp;
    logic [16:0]        r_err;

    logic               found;
    logic [1:0]         hit;
    logic signed [20:0] lo, hi, fv;
    logic [2:0]         n_status;
    logic [1:0]         n_slot;
    logic signed [20:0] n_temp;
    logic [16:0]        n_err;

    assign o_pop = i_q_valid && (!r_valid || i_ready);
    assign lo = $signed({{2{r_low[18]}}, r_low});
    assign hi = $signed({{2{r_high[18]}}, r_high});
    assign fv = $signed({{2{r_fault[18]}}, r_fault});

    // Lowest matching slot wins.
    always_comb begin
        found = 1'b0;
        hit   = '0;
        for (int i = ID_SLOTS - 1; i >= 0; i--) begin
            if (i < SLOT_COUNT && r_sid[i] == i_rec.id) begin
                found = 1'b1;
                hit   = 2'(i);
            end
        end
    end

    always_comb begin
        n_status = i_rec.status;
        n_slot   = '0;
        n_temp   = '0;
        n_err    = r_err;
        if (i_rec.lookup) begin
            if (!found) n_status = ST_ID;
            else if (i_rec.temp_bad) n_status = ST_FORMAT;
            else begin
                n_slot = hit;
                if (i_rec.value >= lo && i_rec.value <= hi) begin
                    n_status = ST_STORED;
                    n_temp   = i_rec.value;
                end else begin
                    n_status = ST_RANGE;
                    n_temp   = fv;
                    n_err    = (r_err == 17'(ERR_WRAP - 1)) ? '0 : 17'(r_err + 17'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ID_SLOTS; i++) r_sid[i] <= '0;
            r_low   <= 19'(-10000);
            r_high  <= 19'd80000;
            r_fault <= 19'd85000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ID0:   r_sid[0] <= i_cfg_data;
                CFG_ID1:   r_sid[1] <= i_cfg_data;
                CFG_ID2:   r_sid[2] <= i_cfg_data;
                CFG_ID3:   r_sid[3] <= i_cfg_data;
                CFG_LOW:   r_low    <= i_cfg_data[18:0];
                CFG_HIGH:  r_high   <= i_cfg_data[18:0];
                CFG_FAULT: r_fault  <= i_cfg_data[18:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_err   <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_err   <= n_err;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_temp   <= n_temp;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_slot        = r_slot;
    assign o_temperature = r_temp;
    assign o_error_total = r_err;

`include "sensor_line_frame_parser_defines.svh"
    `SLFP_ASSERT_NOW(a_err_wrap, i_clk, i_rst_n, 1'b1, r_err < 17'(ERR_WRAP),
                     "error count beyond wrap")
    `SLFP_ASSERT_NEXT(a_err_step, i_clk, i_rst_n, !o_pop, r_err == $past(r_err),
                      "error count moved without a request")

endmodule

// File: design/sensor_line_frame_parser.sv
// Sensor line parser: takes one ASCII byte per cycle on the input channel while
// o_ready is high and, once the header "S0,00" has been seen, returns one result
// per newline giving the line's status, matched slot, stored temperature and the
// out-of-range count. Bytes before sync produce nothing. Throughput is one byte
// per clock while o_ready is high; a result passes through the queue write and
// then the checker output register before it is valid. The byte parser and the
// id/range checker are separated by a two-entry queue, so output back-pressure
// stalls input only once it is full.
// Configuration registers 0-3 are the slot ids, 4/5 the low/high limits and 6 the
// fault value; write them only while no line is in flight. Index 7 is ignored.
module sensor_line_frame_parser import slfp_pkg::*; #(
    parameter int SLOT_COUNT      = 4,
    parameter int MIN_LINE_BYTES  = 30,
    parameter int MAX_LINE_BYTES  = 32,
    parameter int FRACTION_PLACES = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic [1:0]         o_slot,
    output logic signed [20:0] o_temperature,
    output logic [16:0]        o_error_total,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    t_line_rec push_rec, pop_rec;
    logic      push, space, q_valid, pop;

    assign o_cfg_ready = 1'b1;

    slfp_front #(
        .MIN_LINE_BYTES (MIN_LINE_BYTES),
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .FRACTION_PLACES(FRACTION_PLACES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_rx_byte(i_rx_byte),
        .i_space  (space),
        .o_push   (push),
        .o_rec    (push_rec)
    );

    slfp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_rec  (push_rec),
        .o_space(space),
        .o_valid(q_valid),
        .i_pop  (pop),
        .o_rec  (pop_rec)
    );

    slfp_back #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_pop        (pop),
        .i_rec        (pop_rec),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_temperature(o_temperature),
        .o_error_total(o_error_total)
    );

endmodule
